[sv/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_LT  = 4'd6,
        OP_LE  = 4'd7,
        OP_GT  = 4'd8,
        OP_GE  = 4'd9
    } opcode_t;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_MUL  = 2'd1;
    localparam logic [1:0] ERR_ADD  = 2'd2;
    localparam logic [1:0] ERR_DIV0 = 2'd3;

    // cross product picked for the shared multiplier
    localparam logic [1:0] MSEL_AD = 2'd0;
    localparam logic [1:0] MSEL_BC = 2'd1;
    localparam logic [1:0] MSEL_BD = 2'd2;
    localparam logic [1:0] MSEL_AC = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_start;
        logic [1:0] mul_sel;
        logic add_go;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic mul_ovf;
        logic add_ovf;
        logic fin_ovf;
        logic gcd_done;
        logic div_done;
        logic den_zero;
        logic c_zero;
        logic [3:0] op;
    } dp_sts_t;
endpackage

[sv/rau_if.sv]
`timescale 1ns / 1ps
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic signed [63:0] a_num;
    logic [62:0] a_den;
    logic signed [63:0] b_num;
    logic [62:0] b_den;
    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic        cmp_true;
    logic [1:0]  error;
    modport source (output valid, res_num, res_den, cmp_true, error, input ready);
    modport sink (input valid, res_num, res_den, cmp_true, error, output ready);
endinterface

[sv/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// Exact rational arithmetic on two signed operands a_num/a_den and b_num/b_den
// (add, sub, mul, div, and six comparisons). One item is in flight at a time:
// in.ready is high only while the unit is idle. Each cross product runs on
// the bit-serial multiplier; add and sub need three products, mul, div and
// the comparisons two. A fraction result is then added and checked, and
// binary GCD steps and the restoring divider reduce it. Errors found early
// finish sooner. The result stays on the out channel until its transfer
// completes; error codes are 0 ok, 1 multiply overflow, 2 add/sub overflow,
// 3 divide by zero.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input logic clk,
    input logic rst_n,
    rau_in_if.sink   in_ch,
    rau_out_if.source out_ch
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [1:0] err;
    logic cmp_en;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd),
        .err       (err),
        .cmp_en    (cmp_en)
    );

    rau_datapath #(.W(WORD_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (in_ch.opcode),
        .in_a       (in_ch.a_num),
        .in_b       (in_ch.a_den),
        .in_c       (in_ch.b_num),
        .in_d       (in_ch.b_den),
        .out_err    (err),
        .out_cmp_en (cmp_en),
        .res_num    (out_ch.res_num),
        .res_den    (out_ch.res_den),
        .cmp_true   (out_ch.cmp_true)
    );

    // error travels straight from the controller register
    assign out_ch.error = err;
endmodule

[sv/rau_datapath.sv]
`timescale 1ns / 1ps
module rau_datapath
    import rau_pkg::*;
#(
    parameter int W = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  dp_cmd_t cmd,
    output dp_sts_t sts,
    input  logic [3:0] in_op,
    input  logic [63:0] in_a,
    input  logic [62:0] in_b,
    input  logic [63:0] in_c,
    input  logic [62:0] in_d,
    input  logic [1:0] out_err,
    input  logic out_cmp_en,
    output logic signed [63:0] res_num,
    output logic [62:0] res_den,
    output logic cmp_true
);
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [3:0] op_reg;
    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [W-1:0] n1_reg, n2_reg, d1_reg, n3_reg;

    // shift-add multiplier on magnitudes
    logic [W-1:0] my_reg;
    logic [2*W-1:0] mxs_reg, acc_reg;
    logic mneg_reg;
    logic [CW-1:0] mcnt_reg;
    logic [1:0] msel_reg;
    logic mbusy_reg, mdone_reg, movf_reg;

    logic signed [W-1:0] ox, oy;
    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_AD: begin ox = a_reg; oy = d_reg; end
            MSEL_BC: begin ox = b_reg; oy = c_reg; end
            MSEL_BD: begin ox = b_reg; oy = d_reg; end
            default: begin ox = a_reg; oy = c_reg; end
        endcase
    end

    logic [W-1:0] mag_x, mag_y;
    assign mag_x = ox[W-1] ? -ox : ox;
    assign mag_y = oy[W-1] ? -oy : oy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                if (mcnt_reg == CW'(W))
                begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
                else
                    mcnt_reg <= mcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mxs_reg  <= {{W{1'b0}}, mag_x};
            my_reg   <= mag_y;
            acc_reg  <= '0;
            mneg_reg <= ox[W-1] ^ oy[W-1];
            msel_reg <= cmd.mul_sel;
        end
        else if (mbusy_reg && mcnt_reg != CW'(W))
        begin
            if (my_reg[0])
                acc_reg <= acc_reg + mxs_reg;
            mxs_reg <= mxs_reg << 1;
            my_reg  <= my_reg >> 1;
        end
    end

    // a negative product may reach the most negative word, a positive one may not
    logic [2*W-1:0] lim;
    logic mul_ovf_w;
    logic [W-1:0] prod_w;
    assign lim = mneg_reg ? {{W{1'b0}}, MINV} : {{(W+1){1'b0}}, {(W-1){1'b1}}};
    assign mul_ovf_w = acc_reg > lim;
    assign prod_w = mneg_reg ? -acc_reg[W-1:0] : acc_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            movf_reg <= 1'b0;
        else if (cmd.load)
            movf_reg <= 1'b0;
        else if (mdone_reg && mul_ovf_w)
            movf_reg <= 1'b1;
    end

    // add / sub and finish
    logic signed [W:0] sum;
    logic add_ovf_w;
    assign sum = (op_reg == OP_SUB)
               ? ({n1_reg[W-1], n1_reg} - {n2_reg[W-1], n2_reg})
               : ({n1_reg[W-1], n1_reg} + {n2_reg[W-1], n2_reg});
    assign add_ovf_w = sum[W] != sum[W-1];

    logic signed [W-1:0] fn, fd;
    logic fin_ovf_w;
    assign fin_ovf_w = (n3_reg == MINV) || (d1_reg == MINV);
    assign fn = d1_reg[W-1] ? -n3_reg : n3_reg;
    assign fd = d1_reg[W-1] ? -d1_reg : d1_reg;

    logic signed [W-1:0] rn_reg;
    logic [W-1:0] rd_reg;

    // binary gcd
    logic [W-1:0] gu_reg, gv_reg;
    logic [CW-1:0] gk_reg;
    logic gdone_w;
    assign gdone_w = (gv_reg == '0) || (gu_reg == '0);

    // restoring divider: numerator magnitude and denominator by g
    logic [W-1:0] g_reg, rn_rem_reg, rd_rem_reg;
    logic [W-1:0] dn_reg, dd_reg;
    logic [CW-1:0] dcnt_reg;
    logic nneg_reg;
    logic [W:0] tn, td;
    assign tn = {rn_rem_reg, dn_reg[W-1]};
    assign td = {rd_rem_reg, dd_reg[W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            a_reg  <= in_a[W-1:0];
            b_reg  <= {1'b0, in_b[W-2:0]};
            c_reg  <= in_c[W-1:0];
            d_reg  <= {1'b0, in_d[W-2:0]};
        end
        if (mdone_reg)
        begin
            case (msel_reg)
                MSEL_AD: n1_reg <= prod_w;
                MSEL_BC:
                begin
                    if (op_reg == OP_DIV) d1_reg <= prod_w;
                    else n2_reg <= prod_w;
                end
                MSEL_BD: d1_reg <= prod_w;
                default: n1_reg <= prod_w;
            endcase
        end
        if (cmd.add_go)
            n3_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? sum[W-1:0] : n1_reg;
        if (cmd.gcd_start)
        begin
            rn_reg   <= fn;
            rd_reg   <= fd;
            nneg_reg <= fn[W-1];
            gu_reg   <= fn[W-1] ? -fn : fn;
            gv_reg   <= fd;
            gk_reg   <= '0;
        end
        else if (cmd.gcd_step && !gdone_w)
        begin
            if (!gu_reg[0] && !gv_reg[0])
            begin
                gu_reg <= gu_reg >> 1;
                gv_reg <= gv_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gu_reg[0])
                gu_reg <= gu_reg >> 1;
            else if (!gv_reg[0])
                gv_reg <= gv_reg >> 1;
            else if (gu_reg >= gv_reg)
                gu_reg <= (gu_reg - gv_reg) >> 1;
            else
                gv_reg <= (gv_reg - gu_reg) >> 1;
        end
        if (cmd.div_start)
        begin
            g_reg      <= (gu_reg | gv_reg) << gk_reg;
            dn_reg     <= nneg_reg ? -rn_reg : rn_reg;
            dd_reg     <= rd_reg;
            rn_rem_reg <= '0;
            rd_rem_reg <= '0;
            dcnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            dn_reg   <= {dn_reg[W-2:0], (tn >= {1'b0, g_reg})};
            dd_reg   <= {dd_reg[W-2:0], (td >= {1'b0, g_reg})};
            rn_rem_reg <= (tn >= {1'b0, g_reg}) ? W'(tn - {1'b0, g_reg}) : tn[W-1:0];
            rd_rem_reg <= (td >= {1'b0, g_reg}) ? W'(td - {1'b0, g_reg}) : td[W-1:0];
        end
    end

    logic cmp_w;
    always_comb
    begin
        case (op_reg)
            OP_EQ: cmp_w = n1_reg == n2_reg;
            OP_NE: cmp_w = n1_reg != n2_reg;
            OP_LT: cmp_w = n1_reg < n2_reg;
            OP_LE: cmp_w = n1_reg <= n2_reg;
            OP_GT: cmp_w = n1_reg > n2_reg;
            default: cmp_w = n1_reg >= n2_reg;
        endcase
    end

    logic [W-1:0] qnum;
    assign qnum = nneg_reg ? -dn_reg : dn_reg;

    // unused opcodes and errors leave every field at zero
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (out_err == ERR_OK && !out_cmp_en && op_reg <= OP_GE)
            begin
                res_num  <= 64'(signed'(qnum));
                res_den  <= 63'(dd_reg);
                cmp_true <= 1'b0;
            end
            else
            begin
                res_num  <= '0;
                res_den  <= '0;
                cmp_true <= (out_err == ERR_OK) && out_cmp_en && cmp_w;
            end
        end
    end

    always_comb
    begin
        sts.mul_done = mdone_reg;
        sts.mul_ovf  = movf_reg | (mdone_reg & mul_ovf_w);
        sts.add_ovf  = add_ovf_w;
        sts.fin_ovf  = fin_ovf_w;
        sts.gcd_done = gdone_w;
        sts.div_done = dcnt_reg == CW'(W);
        sts.den_zero = (b_reg == '0) || (d_reg == '0);
        sts.c_zero   = c_reg == '0;
        sts.op       = op_reg;
    end
endmodule

[sv/rau_ctrl.sv]
`timescale 1ns / 1ps
module rau_ctrl
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic [1:0] err,
    output logic cmp_en
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL, S_MWAIT, S_ADD, S_FIN, S_GCD, S_DIV, S_OUT, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] err_reg, err_next;
    logic [1:0] mul_idx_reg, mul_idx_next;
    logic cmp_reg, cmp_next;

    // which products each op needs, in order
    logic [1:0] nmul;
    logic [1:0] sel_w;
    always_comb
    begin
        case (sts.op)
            OP_ADD, OP_SUB: nmul = 2'd3;
            OP_MUL, OP_DIV: nmul = 2'd2;
            default:        nmul = 2'd2;
        endcase
        case (sts.op)
            OP_MUL:  sel_w = (mul_idx_reg == 2'd0) ? MSEL_AC : MSEL_BD;
            OP_DIV:  sel_w = (mul_idx_reg == 2'd0) ? MSEL_AD : MSEL_BC;
            default: sel_w = (mul_idx_reg == 2'd0) ? MSEL_AD
                           : (mul_idx_reg == 2'd1) ? MSEL_BC : MSEL_BD;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        err_next     = err_reg;
        mul_idx_next = mul_idx_reg;
        cmp_next     = cmp_reg;
        cmd          = '0;
        cmd.mul_sel  = sel_w;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    err_next   = ERR_OK;
                    cmp_next   = 1'b0;
                    mul_idx_next = 2'd0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.op > OP_GE)
                    state_next = S_OUT;
                else if (sts.den_zero || (sts.op == OP_DIV && sts.c_zero))
                begin
                    err_next = ERR_DIV0;
                    state_next = S_OUT;
                end
                else
                begin
                    cmp_next = sts.op >= OP_EQ;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    if (mul_idx_reg + 2'd1 == nmul)
                    begin
                        if (sts.mul_ovf)
                        begin
                            err_next = ERR_MUL;
                            state_next = S_OUT;
                        end
                        else if (cmp_reg)
                            state_next = S_OUT;
                        else
                            state_next = S_ADD;
                    end
                    else
                    begin
                        mul_idx_next = mul_idx_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_ADD:
            begin
                if ((sts.op == OP_ADD || sts.op == OP_SUB) && sts.add_ovf)
                begin
                    err_next = ERR_ADD;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.add_go = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.fin_ovf)
                begin
                    err_next = (sts.op == OP_ADD || sts.op == OP_SUB) ? ERR_ADD : ERR_MUL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.gcd_start = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                cmd.gcd_step = 1'b1;
                if (sts.gcd_done)
                begin
                    cmd.gcd_step = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
                else
                    cmd.div_step = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            err_reg     <= ERR_OK;
            mul_idx_reg <= 2'd0;
            cmp_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            err_reg     <= err_next;
            mul_idx_reg <= mul_idx_next;
            cmp_reg     <= cmp_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_HOLD;
    assign err       = err_reg;
    assign cmp_en    = cmp_reg;
endmodule

[sv/rau_checker.sv]
`timescale 1ns / 1ps
module rau_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [62:0] res_den,
    input logic cmp_true,
    input logic [1:0] error
);
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second transfer while busy");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != 2'd0 |-> res_den == '0 && !cmp_true)
        else $error("error result carries data");
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmp_true |-> res_den == '0) else $error("compare with fraction");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(error))
        else $error("result dropped");
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_den   (out_ch.res_den),
    .cmp_true  (out_ch.cmp_true),
    .error     (out_ch.error)
);

[tb/tb_rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    localparam int CLK_HALF = 4;

    typedef struct {
        logic [3:0]  opcode;
        logic [63:0] a_num;
        logic [62:0] a_den;
        logic [63:0] b_num;
        logic [62:0] b_den;
    } operands_t;

    typedef struct {
        logic [63:0] res_num;
        logic [62:0] res_den;
        logic        cmp_true;
        logic [1:0]  error;
    } quotient_t;

    logic clk;
    logic rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit_core #(.WORD_BITS(64)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Stimulus waiting for the driver, and results predicted per transfer.
    operands_t pending_ops[$];
    quotient_t expected_results[$];

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    bit in_taken;
    operands_t drv_item;
    operands_t mon_item;
    quotient_t mon_exp;
    quotient_t mon_got;

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Predictor: 64-bit signed words, overflow checked through 128-bit
    // intermediates, so the word limits fall out of a plain range test.
    // ------------------------------------------------------------------
    localparam logic signed [127:0] WMAX = 128'sh7fff_ffff_ffff_ffff;
    localparam logic signed [127:0] WMIN = -128'sh8000_0000_0000_0000;

    function automatic bit out_of_word(input logic signed [127:0] v);
        return (v > WMAX) || (v < WMIN);
    endfunction

    function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Move the sign to the numerator and reduce; returns nonzero error on
    // a most negative numerator or denominator.
    function automatic logic [1:0] reduce_fraction(input logic signed [127:0] n,
                                                   input logic signed [127:0] d,
                                                   input logic [1:0] ovf_code,
                                                   output quotient_t r);
        logic [63:0] g;
        logic [63:0] mag;
        r = '{default: '0};
        if (n == WMIN || d == WMIN)
            return ovf_code;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        mag = (n < 0) ? 64'(-n) : 64'(n);
        g = gcd_of(mag, 64'(d));
        r.res_num = 64'(n / $signed({64'd0, g}));
        r.res_den = 63'(d / $signed({64'd0, g}));
        return ERR_OK;
    endfunction

    function automatic quotient_t rational_result(input operands_t it);
        logic signed [127:0] a, b, c, d, n1, n2, n3, d1;
        quotient_t r;
        logic [1:0] err;
        bit t;
        a = $signed(it.a_num);
        b = $signed({65'd0, it.a_den});
        c = $signed(it.b_num);
        d = $signed({65'd0, it.b_den});
        r = '{default: '0};
        err = ERR_OK;
        t = 1'b0;
        if (it.opcode > OP_GE)
            return r;
        if (b == 0 || d == 0)
            err = ERR_DIV0;
        else if (it.opcode == OP_ADD || it.opcode == OP_SUB)
        begin
            n1 = a * d;
            n2 = b * c;
            d1 = b * d;
            if (out_of_word(n1) || out_of_word(n2) || out_of_word(d1))
                err = ERR_MUL;
            else
            begin
                n3 = (it.opcode == OP_ADD) ? n1 + n2 : n1 - n2;
                if (out_of_word(n3))
                    err = ERR_ADD;
                else
                    err = reduce_fraction(n3, d1, ERR_ADD, r);
            end
        end
        else if (it.opcode == OP_MUL)
        begin
            n1 = a * c;
            d1 = b * d;
            if (out_of_word(n1) || out_of_word(d1))
                err = ERR_MUL;
            else
                err = reduce_fraction(n1, d1, ERR_MUL, r);
        end
        else if (it.opcode == OP_DIV)
        begin
            n1 = a * d;
            d1 = b * c;
            if (c == 0)
                err = ERR_DIV0;
            else if (out_of_word(n1) || out_of_word(d1))
                err = ERR_MUL;
            else
                err = reduce_fraction(n1, d1, ERR_MUL, r);
        end
        else
        begin
            n1 = a * d;
            n2 = b * c;
            if (out_of_word(n1) || out_of_word(n2))
                err = ERR_MUL;
            else
            begin
                case (it.opcode)
                    OP_EQ:   t = (n1 == n2);
                    OP_NE:   t = (n1 != n2);
                    OP_LT:   t = (n1 < n2);
                    OP_LE:   t = (n1 <= n2);
                    OP_GT:   t = (n1 > n2);
                    default: t = (n1 >= n2);
                endcase
                r.cmp_true = t;
            end
        end
        if (err != ERR_OK)
            r = '{default: '0};
        r.error = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pick a numerator: mostly small so the arithmetic succeeds, sometimes
    // full width or an extreme to hit the overflow paths.
    function automatic logic [63:0] pick_num();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return rand64();
            1:       return 64'h8000_0000_0000_0000;
            2:       return 64'h7fff_ffff_ffff_ffff;
            3:       return 64'd0;
            4, 5:    return 64'($signed(32'($urandom())));
            default: return 64'($signed(16'($urandom())));
        endcase
    endfunction

    function automatic logic [62:0] pick_den();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0:       return 63'(rand64());
            1:       return 63'h7fff_ffff_ffff_ffff;
            2:       return 63'd0;
            3, 4:    return 63'({1'b0, $urandom()});
            default: return 63'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic queue_item(input logic [3:0] op, input logic [63:0] an,
                              input logic [62:0] ad, input logic [63:0] bn,
                              input logic [62:0] bd);
        operands_t it;
        it.opcode = op;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        pending_ops.push_back(it);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_item(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 9)
                                                       : $urandom_range(0, 15)),
                       pick_num(), pick_den(), pick_num(), pick_den());
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the head of the queue at the falling edge, advance
    // only after a transfer. Valid stays up while the item waits.
    // ------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            in_ch.opcode <= '0;
            in_ch.a_num  <= '0;
            in_ch.a_den  <= '0;
            in_ch.b_num  <= '0;
            in_ch.b_den  <= '0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drv_item = pending_ops.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.opcode <= drv_item.opcode;
                in_ch.a_num  <= drv_item.a_num;
                in_ch.a_den  <= drv_item.a_den;
                in_ch.b_num  <= drv_item.b_num;
                in_ch.b_den  <= drv_item.b_den;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: drop ready on the idle share of cycles.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, compare on each result.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                mon_item.opcode = in_ch.opcode;
                mon_item.a_num  = in_ch.a_num;
                mon_item.a_den  = in_ch.a_den;
                mon_item.b_num  = in_ch.b_num;
                mon_item.b_den  = in_ch.b_den;
                expected_results.push_back(rational_result(mon_item));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                mon_got.res_num  = out_ch.res_num;
                mon_got.res_den  = out_ch.res_den;
                mon_got.cmp_true = out_ch.cmp_true;
                mon_got.error    = out_ch.error;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: num=%h den=%h cmp=%b err=%0d",
                                 mon_got.res_num, mon_got.res_den, mon_got.cmp_true,
                                 mon_got.error);
                    mismatches++;
                end
                else
                begin
                    mon_exp = expected_results.pop_front();
                    if (mon_got.res_num !== mon_exp.res_num
                        || mon_got.res_den !== mon_exp.res_den
                        || mon_got.cmp_true !== mon_exp.cmp_true
                        || mon_got.error !== mon_exp.error)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected num=%h den=%h cmp=%b err=%0d, got num=%h den=%h cmp=%b err=%0d",
                                     mon_exp.res_num, mon_exp.res_den, mon_exp.cmp_true,
                                     mon_exp.error, mon_got.res_num, mon_got.res_den,
                                     mon_got.cmp_true, mon_got.error);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, then three idle patterns.
    // ------------------------------------------------------------------
    initial
    begin
        mismatches = 0;
        send_idle_pct = 32;
        recv_idle_pct = 80;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_item(OP_ADD, 64'd1, 63'd2, 64'd1, 63'd3);
        queue_item(OP_SUB, 64'd1, 63'd2, 64'd1, 63'd2);
        queue_item(OP_MUL, -64'sd6, 63'd4, 64'd2, 63'd9);
        queue_item(OP_DIV, 64'd3, 63'd4, -64'sd9, 63'd8);
        queue_item(OP_DIV, 64'd3, 63'd4, 64'd0, 63'd8);
        queue_item(OP_LT, -64'sd1, 63'd3, 64'd1, 63'd5);
        queue_item(OP_ADD, 64'h8000_0000_0000_0000, 63'd1, 64'd0, 63'd1);
        queue_item(4'd12, 64'd5, 63'd7, 64'd5, 63'd7);
        queue_random(660);
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 32;
        queue_random(666);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(666);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("** rational_arithmetic_unit_core: PASSED **");
        else
            $display("** rational_arithmetic_unit_core: FAILED **");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("** rational_arithmetic_unit_core: FAILED **");
        $finish;
    end

endmodule
